// File: rtl/drt_pkg.sv
// Package for the dirty rectangle tracker: rectangle type, operation codes,
// sequencer states and the saturating box arithmetic.
// No dependencies.
package drt_pkg;

	typedef struct packed {
		logic signed [15:0] h;
		logic signed [15:0] w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} box_t;

	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		OP_RESET     = 3'd0,
		OP_MARK_ALL  = 3'd1,
		OP_ADD       = 3'd2,
		OP_TEST      = 3'd3,
		OP_BOUNDS    = 3'd4,
		OP_CLIP      = 3'd5,
		OP_TRANSLATE = 3'd6,
		OP_ANY       = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} state_t;

	// Clamp an 18-bit signed value into 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'sd32767)
			r = 16'sh7fff;
		else if (v < -18'sd32768)
			r = 16'sh8000;
		else
			r = v[15:0];
		return r;
	endfunction

	// Far edge of a span: start plus size, one extra bit.
	function automatic logic signed [16:0] span_end(input logic signed [15:0] p,
		input logic signed [15:0] s);
		return 17'(p) + 17'(s);
	endfunction

	function automatic logic signed [15:0] smin(input logic signed [15:0] a,
		input logic signed [15:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic signed [15:0] smax(input logic signed [15:0] a,
		input logic signed [15:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [16:0] emax(input logic signed [16:0] a,
		input logic signed [16:0] b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic signed [16:0] emin(input logic signed [16:0] a,
		input logic signed [16:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic is_empty(input box_t b);
		return (b.w <= 16'sd0) || (b.h <= 16'sd0);
	endfunction

	// Smallest box holding both operands; size saturates.
	function automatic box_t box_union(input box_t a, input box_t b);
		box_t r;
		logic signed [16:0] x1, y1;
		r.x = smin(a.x, b.x);
		r.y = smin(a.y, b.y);
		x1 = emax(span_end(a.x, a.w), span_end(b.x, b.w));
		y1 = emax(span_end(a.y, a.h), span_end(b.y, b.h));
		r.w = sat16(18'(x1) - 18'(r.x));
		r.h = sat16(18'(y1) - 18'(r.y));
		return r;
	endfunction

	// Intersection of two boxes; size saturates and may be empty.
	function automatic box_t box_clip(input box_t a, input box_t b);
		box_t r;
		logic signed [16:0] x1, y1;
		r.x = smax(a.x, b.x);
		r.y = smax(a.y, b.y);
		x1 = emin(span_end(a.x, a.w), span_end(b.x, b.w));
		y1 = emin(span_end(a.y, a.h), span_end(b.y, b.h));
		r.w = sat16(18'(x1) - 18'(r.x));
		r.h = sat16(18'(y1) - 18'(r.y));
		return r;
	endfunction

endpackage

// File: rtl/drt_cell.sv
// One storage cell of the rectangle ring: holds a single entry and takes
// its neighbor's entry on a shift. Depends on drt_pkg.
module drt_cell import drt_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  box_t      shift_in,
	input  box_t      wr_data,
	output box_t      entry
);

	box_t entry_q;

	always_ff @(posedge clk) begin
		if (ctl.wr)
			entry_q <= wr_data;
		else if (ctl.shift)
			entry_q <= shift_in;
	end

	assign entry = entry_q;

endmodule

// File: rtl/dirty_rectangle_tracker_top.sv
// Top level of the dirty rectangle tracker: sequencer, shared entry unit,
// result register and the ring of drt_cell. Depends on drt_pkg, drt_cell.
//
// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      tuser: op; tdata: rect x,y,w,h, shift x,y
// m_*      out  m_tvalid / m_tready      tdata: flag, x,y,w,h; tlast: last
//
// Reset, mark-all and any go from accept straight to finish. Add, test, bounds,
// clip-walk and translate run in between while the ring turns once through all
// cells, one entry a cycle past the shared unit at cell 0 unless the ring is held.
// A word is accepted only while the sequencer is idle.
// Reset clears the count, the all-dirty flag, the sequencer and the output
// valid; stored entries are not cleared and only valid ones are ever read.
// A stalled output holds the ring whenever clip-walk has a new word to push.
module dirty_rectangle_tracker_top import drt_pkg::*; #(
	parameter int MAX_RECTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,  // op
	input  logic [95:0] s_tdata,  // rect_x, rect_y, rect_w, rect_h, shift_x, shift_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // flag, out_x, out_y, out_w, out_h, zero fill
	output logic        m_tlast
);

	localparam int CW = $clog2(MAX_RECTS + 1);
	localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

	state_t state_q, state_d;
	op_t    op_q;
	box_t   r_q;
	logic signed [15:0] dx_q, dy_q;
	logic [IW-1:0] idx_q;
	logic [CW-1:0] count_q;
	logic all_dirty_q;
	logic hit_q, cov_q;
	box_t acc_q;
	box_t pend_q;
	logic pend_v_q;

	logic obuf_v_q, obuf_flag_q, obuf_last_q;
	box_t obuf_box_q;

	box_t cell_out [MAX_RECTS];
	box_t head, head_mod, clip_b, tail_in, wr_box;
	logic in_range, ov, cov, clip_ok, obuf_free, push_need, step, fin_go;
	logic push, push_flag, push_last, do_store, r_empty;
	box_t push_box;
	logic [IW-1:0] wr_idx;
	logic accept;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign head      = cell_out[0];
	assign in_range  = CW'(idx_q) < count_q;
	assign r_empty   = is_empty(r_q);
	assign obuf_free = !obuf_v_q || m_tready;

	// Shared unit: compares, clips or moves the entry at the ring head.
	always_comb begin
		ov = !r_empty &&
			(18'(r_q.x) < 18'(span_end(head.x, head.w))) &&
			(18'(head.x) < 18'(span_end(r_q.x, r_q.w))) &&
			(18'(r_q.y) < 18'(span_end(head.y, head.h))) &&
			(18'(head.y) < 18'(span_end(r_q.y, r_q.h)));
		cov = (r_q.x >= head.x) && (r_q.y >= head.y) &&
			(span_end(r_q.x, r_q.w) <= span_end(head.x, head.w)) &&
			(span_end(r_q.y, r_q.h) <= span_end(head.y, head.h));
		clip_b  = box_clip(r_q, head);
		clip_ok = !is_empty(clip_b);
		head_mod = head;
		if (op_q == OP_TRANSLATE && in_range) begin
			head_mod.x = sat16(18'(head.x) + 18'(dx_q));
			head_mod.y = sat16(18'(head.y) + 18'(dy_q));
		end
		tail_in = head_mod;
	end

	// Sequencer: next state, result pushes and the add write.
	always_comb begin
		state_d   = state_q;
		step      = 1'b0;
		fin_go    = 1'b0;
		push      = 1'b0;
		push_flag = 1'b0;
		push_last = 1'b0;
		push_box  = '0;
		push_need = (op_q == OP_CLIP) && in_range && clip_ok && pend_v_q;
		do_store  = 1'b0;
		wr_idx    = count_q[IW-1:0];
		wr_box    = r_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(s_tuser))
						OP_ADD, OP_TEST, OP_BOUNDS, OP_CLIP, OP_TRANSLATE: state_d = ST_RUN;
						default: state_d = ST_FIN;
					endcase
				end
			end
			ST_RUN: begin
				if (!push_need || obuf_free) begin
					step = 1'b1;
					if (push_need) begin
						push     = 1'b1;
						push_box = pend_q;
					end
					if (idx_q == IW'(MAX_RECTS - 1))
						state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				case (op_q)
					OP_TEST: begin
						push      = obuf_free;
						push_flag = all_dirty_q || hit_q;
						push_last = 1'b1;
					end
					OP_ANY: begin
						push      = obuf_free;
						push_flag = all_dirty_q || (count_q != '0);
						push_last = 1'b1;
					end
					OP_BOUNDS: begin
						push      = obuf_free;
						push_last = 1'b1;
						if (all_dirty_q)
							push_box = r_q;
						else if (count_q != '0)
							push_box = acc_q;
					end
					OP_CLIP: begin
						push      = obuf_free && (all_dirty_q || pend_v_q);
						push_last = 1'b1;
						push_box  = all_dirty_q ? r_q : pend_q;
					end
					OP_ADD: begin
						do_store = !all_dirty_q && !r_empty && !cov_q;
						if (count_q == CW'(MAX_RECTS)) begin
							wr_idx = '0;
							wr_box = box_union(acc_q, r_q);
						end
					end
					default: ;
				endcase
				case (op_q)
					OP_TEST, OP_ANY, OP_BOUNDS: fin_go = obuf_free;
					OP_CLIP: fin_go = obuf_free || !(all_dirty_q || pend_v_q);
					default: fin_go = 1'b1;
				endcase
				if (fin_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			all_dirty_q <= 1'b0;
			pend_v_q    <= 1'b0;
			idx_q       <= '0;
			obuf_v_q    <= 1'b0;
		end else begin
			if (accept) begin
				idx_q    <= '0;
				pend_v_q <= 1'b0;
			end
			if (step) begin
				idx_q <= idx_q + 1'b1;
				if (op_q == OP_CLIP && in_range && clip_ok)
					pend_v_q <= 1'b1;
			end
			if (state_q == ST_FIN && fin_go) begin
				case (op_q)
					OP_RESET: begin
						count_q     <= '0;
						all_dirty_q <= 1'b0;
					end
					OP_MARK_ALL: begin
						count_q     <= '0;
						all_dirty_q <= 1'b1;
					end
					OP_ADD: begin
						if (do_store)
							count_q <= (count_q == CW'(MAX_RECTS)) ? CW'(1) : count_q + 1'b1;
					end
					default: ;
				endcase
			end
			if (push)
				obuf_v_q <= 1'b1;
			else if (m_tready)
				obuf_v_q <= 1'b0;
		end
	end

	// Operand, accumulator and result payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(s_tuser);
			r_q.x <= s_tdata[15:0];
			r_q.y <= s_tdata[31:16];
			r_q.w <= s_tdata[47:32];
			r_q.h <= s_tdata[63:48];
			dx_q  <= s_tdata[79:64];
			dy_q  <= s_tdata[95:80];
			hit_q <= 1'b0;
			cov_q <= 1'b0;
		end
		if (step) begin
			if (in_range) begin
				hit_q <= hit_q || ov;
				cov_q <= cov_q || cov;
				acc_q <= (idx_q == '0) ? head : box_union(acc_q, head);
				if (op_q == OP_CLIP && clip_ok)
					pend_q <= clip_b;
			end
		end
		if (push) begin
			obuf_flag_q <= push_flag;
			obuf_last_q <= push_last;
			obuf_box_q  <= push_box;
		end
	end

	// Ring of cells: cell k takes cell k+1, the last cell takes the head.
	for (genvar k = 0; k < MAX_RECTS; k++) begin : g_cell
		cell_ctl_t ctl;
		box_t      nb;
		assign ctl.shift = step;
		assign ctl.wr    = (state_q == ST_FIN) && do_store && (wr_idx == IW'(k));
		if (k == MAX_RECTS - 1) begin : g_tail
			assign nb = tail_in;
		end else begin : g_mid
			assign nb = cell_out[k+1];
		end
		drt_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.shift_in (nb),
			.wr_data  (wr_box),
			.entry    (cell_out[k])
		);
	end

	assign m_tvalid = obuf_v_q;
	assign m_tlast  = obuf_last_q;
	assign m_tdata  = {7'd0, obuf_box_q.h, obuf_box_q.w, obuf_box_q.y, obuf_box_q.x,
		obuf_flag_q};

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready)
		else $error("input taken while busy");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_RECTS))
		else $error("entry count beyond table size");
	a_dirty_empty: assert property (@(posedge clk) disable iff (!arst_n)
		all_dirty_q |-> (count_q == '0))
		else $error("entries kept while all dirty");
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> obuf_free)
		else $error("result overwrote a waiting word");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for dirty_rectangle_tracker_top: directed and random
// operation words, a scoreboard that predicts every result word, random stalls.
// Depends on drt_pkg and the tracker RTL.
module testbench;
	import drt_pkg::*;

	localparam int MAX_RECTS = 16;
	localparam int TAIL_CYCLES = MAX_RECTS + 8;

	typedef struct {
		int x, y, w, h;
	} rect_t;

	typedef struct {
		logic flag;
		int   x, y, w, h;
		logic last;
	} result_t;

	// Tracks the rectangle table and predicts the result words of each operation.
	class rect_scoreboard;
		rect_t   table_q[MAX_RECTS];
		int      n_entries;
		bit      all_dirty;
		result_t expected_q[$];
		int      errors;

		function int sat16(int v);
			if (v > 32767)
				return 32767;
			if (v < -32768)
				return -32768;
			return v;
		endfunction

		function bit empty_rect(rect_t r);
			return r.w <= 0 || r.h <= 0;
		endfunction

		function int imin(int a, int b);
			return a < b ? a : b;
		endfunction

		function int imax(int a, int b);
			return a > b ? a : b;
		endfunction

		function rect_t merge(rect_t a, rect_t b);
			rect_t r;
			r.x = imin(a.x, b.x);
			r.y = imin(a.y, b.y);
			r.w = sat16(imax(a.x + a.w, b.x + b.w) - r.x);
			r.h = sat16(imax(a.y + a.h, b.y + b.h) - r.y);
			return r;
		endfunction

		function void push(logic flag, rect_t r, logic last);
			result_t e;
			e.flag = flag;
			e.x = r.x;
			e.y = r.y;
			e.w = r.w;
			e.h = r.h;
			e.last = last;
			expected_q.push_back(e);
		endfunction

		function void add_rect(rect_t r);
			if (all_dirty || empty_rect(r))
				return;
			for (int i = 0; i < n_entries; i++)
				if (r.x >= table_q[i].x && r.y >= table_q[i].y &&
						r.x + r.w <= table_q[i].x + table_q[i].w &&
						r.y + r.h <= table_q[i].y + table_q[i].h)
					return;
			if (n_entries < MAX_RECTS) begin
				table_q[n_entries] = r;
				n_entries++;
				return;
			end
			for (int i = 1; i < MAX_RECTS; i++)
				table_q[0] = merge(table_q[0], table_q[i]);
			n_entries = 1;
			table_q[0] = merge(table_q[0], r);
		endfunction

		// Called for every accepted input word.
		function void note_input(op_t op, rect_t r, int dx, int dy);
			rect_t   zero_r;
			rect_t   b;
			rect_t   e;
			bit      hit;
			int      first_clip;
			zero_r = '{0, 0, 0, 0};
			case (op)
				OP_RESET: begin
					n_entries = 0;
					all_dirty = 0;
				end
				OP_MARK_ALL: begin
					all_dirty = 1;
					n_entries = 0;
				end
				OP_ADD: add_rect(r);
				OP_TEST: begin
					hit = all_dirty;
					if (!hit && !empty_rect(r))
						for (int i = 0; i < n_entries; i++) begin
							e = table_q[i];
							if (r.x < e.x + e.w && e.x < r.x + r.w &&
									r.y < e.y + e.h && e.y < r.y + r.h)
								hit = 1;
						end
					push(hit, zero_r, 1'b1);
				end
				OP_BOUNDS: begin
					if (all_dirty)
						b = r;
					else if (n_entries == 0)
						b = zero_r;
					else begin
						b = table_q[0];
						for (int i = 1; i < n_entries; i++)
							b = merge(b, table_q[i]);
					end
					push(1'b0, b, 1'b1);
				end
				OP_CLIP: begin
					if (all_dirty)
						push(1'b0, r, 1'b1);
					else begin
						first_clip = expected_q.size();
						for (int i = 0; i < n_entries; i++) begin
							e = table_q[i];
							b.x = imax(r.x, e.x);
							b.y = imax(r.y, e.y);
							b.w = sat16(imin(r.x + r.w, e.x + e.w) - b.x);
							b.h = sat16(imin(r.y + r.h, e.y + e.h) - b.y);
							if (!empty_rect(b))
								push(1'b0, b, 1'b0);
						end
						// The final word of a non-empty walk carries the last mark.
						if (expected_q.size() > first_clip)
							expected_q[expected_q.size() - 1].last = 1'b1;
					end
				end
				OP_TRANSLATE: begin
					if (!all_dirty)
						for (int i = 0; i < n_entries; i++) begin
							table_q[i].x = sat16(table_q[i].x + dx);
							table_q[i].y = sat16(table_q[i].y + dy);
						end
				end
				default: push(all_dirty || n_entries > 0, zero_r, 1'b1);
			endcase
		endfunction

		// Called for every accepted result word.
		function void check_result(logic [71:0] data, logic last);
			result_t e;
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected: data=%h last=%b", data, last);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (data[0] !== e.flag) begin
				$error("flag: expected %0d, got %0d", e.flag, data[0]);
				errors++;
			end
			if ($signed(data[16:1]) !== 16'(e.x)) begin
				$error("out_x: expected %0d, got %0d", e.x, $signed(data[16:1]));
				errors++;
			end
			if ($signed(data[32:17]) !== 16'(e.y)) begin
				$error("out_y: expected %0d, got %0d", e.y, $signed(data[32:17]));
				errors++;
			end
			if ($signed(data[48:33]) !== 16'(e.w)) begin
				$error("out_w: expected %0d, got %0d", e.w, $signed(data[48:33]));
				errors++;
			end
			if ($signed(data[64:49]) !== 16'(e.h)) begin
				$error("out_h: expected %0d, got %0d", e.h, $signed(data[64:49]));
				errors++;
			end
			if (last !== e.last) begin
				$error("last: expected %0d, got %0d", e.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [2:0]  s_tuser;   // op
	logic [95:0] s_tdata;   // rect_x, rect_y, rect_w, rect_h, shift_x, shift_y
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;   // flag, out_x, out_y, out_w, out_h, zero fill
	logic        m_tlast;

	rect_scoreboard sb;
	bit  quiet;        // no gaps on either side while set
	bit  hold_request; // asks the receiver for one long hold-off
	int  stall_left;

	dirty_rectangle_tracker_top #(.MAX_RECTS(MAX_RECTS)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (quiet || p < 60)
			return 0;
		if (p < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Small coordinates so that rectangles meet; sometimes the full range.
	function automatic int pick_coord();
		if ($urandom_range(0, 9) == 0)
			return $signed(16'($urandom));
		return $urandom_range(0, 160) - 80;
	endfunction

	function automatic int pick_size();
		int p;
		p = $urandom_range(0, 19);
		if (p == 0)
			return $signed(16'($urandom));
		if (p == 1)
			return -$urandom_range(0, 5);
		return $urandom_range(1, 48);
	endfunction

	function automatic rect_t pick_rect();
		rect_t r;
		r.x = pick_coord();
		r.y = pick_coord();
		r.w = pick_size();
		r.h = pick_size();
		return r;
	endfunction

	// Offers one word at a falling edge and returns at the falling edge after
	// the handshake, so the valid line is written once per step.
	task automatic send_word(op_t op, rect_t r, int dx = 0, int dy = 0);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = op;
		s_tdata  = {16'(dy), 16'(dx), 16'(r.h), 16'(r.w), 16'(r.y), 16'(r.x)};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_input(op, r, dx, dy);
		@(negedge clk);
	endtask

	// Receiver: random stalls plus one long hold-off on request so the block
	// backs up into its input.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			stall_left = 400;
		end
		if (stall_left > 0) begin
			m_tready = 1'b0;
			stall_left--;
		end else begin
			m_tready = 1'b1;
			if (!quiet && $urandom_range(0, 99) < 20)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tlast);

	// Stimulus and end of run.
	initial begin
		rect_t r;
		int    p;
		op_t   op;
		sb = new();
		s_tvalid = 1'b0;
		s_tuser  = OP_RESET;
		s_tdata  = '0;
		m_tready = 1'b0;
		arst_n   = 1'b0;
		quiet    = 1'b1;
		hold_request = 1'b0;
		stall_left = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part: empty table, ignored adds, half-open edges, translate
		// saturation, table overflow merge, all-dirty behavior.
		send_word(OP_ANY, '{0, 0, 0, 0});
		send_word(OP_BOUNDS, '{5, 5, 5, 5});
		send_word(OP_CLIP, '{-100, -100, 300, 300});
		send_word(OP_ADD, '{0, 0, 0, 10});
		send_word(OP_ADD, '{0, 0, 10, -32768});
		send_word(OP_ADD, '{0, 0, 10, 10});
		send_word(OP_ADD, '{2, 2, 3, 3});
		send_word(OP_ADD, '{20, 20, 5, 5});
		send_word(OP_TEST, '{10, 0, 5, 5});
		send_word(OP_TEST, '{9, 9, 0, 5});
		send_word(OP_TEST, '{9, 9, 1, 1});
		send_word(OP_BOUNDS, '{0, 0, 0, 0});
		send_word(OP_CLIP, '{5, 5, 20, 20});
		send_word(OP_ADD, '{32767, -32768, 32767, 32767});
		send_word(OP_TRANSLATE, '{0, 0, 0, 0}, 32767, -32768);
		send_word(OP_BOUNDS, '{0, 0, 0, 0});
		send_word(OP_CLIP, '{-32768, -32768, 32767, 32767});
		for (int i = 0; i < 15; i++)
			send_word(OP_ADD, '{-32768 + 40 * i, 100 * i, 7, 9});
		send_word(OP_BOUNDS, '{0, 0, 0, 0});
		send_word(OP_ANY, '{0, 0, 0, 0});
		send_word(OP_MARK_ALL, '{0, 0, 0, 0});
		send_word(OP_ADD, '{1, 1, 4, 4});
		send_word(OP_TEST, '{1, 1, -1, 0});
		send_word(OP_BOUNDS, '{-32768, 32767, -32768, 32767});
		send_word(OP_CLIP, '{3, 4, 0, -7});
		send_word(OP_TRANSLATE, '{0, 0, 0, 0}, 5, 5);
		send_word(OP_ANY, '{0, 0, 0, 0});
		send_word(OP_RESET, '{0, 0, 0, 0});
		send_word(OP_ANY, '{0, 0, 0, 0});

		// Random part: mostly adds and clip-walks on a busy table.
		for (int n = 0; n < 165; n++) begin
			quiet = (n >= 60 && n < 90);
			if (n == 120)
				hold_request = 1'b1;
			p = $urandom_range(0, 99);
			if (p < 36)
				op = OP_ADD;
			else if (p < 48)
				op = OP_TEST;
			else if (p < 58)
				op = OP_BOUNDS;
			else if (p < 80)
				op = OP_CLIP;
			else if (p < 88)
				op = OP_TRANSLATE;
			else if (p < 93)
				op = OP_ANY;
			else if (p < 97)
				op = OP_RESET;
			else
				op = OP_MARK_ALL;
			r = pick_rect();
			if (op == OP_CLIP && $urandom_range(0, 1))
				r = '{-200, -200, 400, 400};
			if ($urandom_range(0, 7) == 0)
				send_word(op, r, $signed(16'($urandom)), $signed(16'($urandom)));
			else
				send_word(op, r, $urandom_range(0, 20) - 10, $urandom_range(0, 20) - 10);
			// Leave all-dirty soon so the table keeps filling.
			if (op == OP_MARK_ALL)
				send_word(OP_RESET, pick_rect());
		end
		s_tvalid = 1'b0;
		quiet = 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

// File: dirty_rectangle_tracker_top.f
rtl/drt_pkg.sv
rtl/drt_cell.sv
rtl/dirty_rectangle_tracker_top.sv
tb/sv/testbench.sv
